// ===== rtl/core/fpv3_pkg.sv =====
// ----------------------------------------------------------------------------
// fpv3_pkg
// Shared types and constants of the fixed point three-component vector unit.
// ----------------------------------------------------------------------------
package fpv3_pkg;

  // default fraction width of the fixed point format
  localparam int FRAC_BITS_DEF = 16;
  // width of every vector component and scalar
  localparam int WORD_W = 32;
  // number of vector lanes
  localparam int LANES = 3;

  // operation codes
  typedef enum logic [2:0] {
    KIND_ADD   = 3'd0,
    KIND_SUB   = 3'd1,
    KIND_SCALE = 3'd2,
    KIND_DOT   = 3'd3,
    KIND_CROSS = 3'd4,
    KIND_MAG   = 3'd5,
    KIND_NORM  = 3'd6
  } kind_e;

  // sideband that travels with a word through the root and divide stages
  typedef struct packed {
    kind_e             kind;
    logic [WORD_W-1:0] ax;
    logic [WORD_W-1:0] ay;
    logic [WORD_W-1:0] az;
    logic [WORD_W-1:0] rx;
    logic [WORD_W-1:0] ry;
    logic [WORD_W-1:0] rz;
    logic [WORD_W-1:0] sc;
  } meta_t;

endpackage

// ===== rtl/core/fpv3_sqrt.sv =====
// ----------------------------------------------------------------------------
// fpv3_sqrt
// Pipelined integer square root of the self-dot shifted up by the fraction
// width, one root bit per register stage.
// ----------------------------------------------------------------------------
module fpv3_sqrt #(
  parameter int FRAC_BITS = fpv3_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  fpv3_pkg::meta_t                               meta_i,
  input  logic [fpv3_pkg::WORD_W-1:0]                   rad_i,
  output logic                                          valid_o,
  output fpv3_pkg::meta_t                               meta_o,
  output logic [(fpv3_pkg::WORD_W+FRAC_BITS)/2-1:0]     root_o
);
  import fpv3_pkg::*;

  localparam int RW  = (WORD_W + FRAC_BITS) / 2;
  localparam int XW  = 2 * RW;
  localparam int RMW = RW + 2;

  logic             v_q    [RW];
  meta_t            meta_q [RW];
  logic [RMW-1:0]   rem_q  [RW];
  logic [RW-1:0]    root_q [RW];
  logic [XW-1:0]    x_q    [RW];
  logic [XW-1:0]    x_first;

  // negative argument gives a zero root
  assign x_first = rad_i[WORD_W-1] ? '0 :
                   XW'({rad_i[WORD_W-2:0], {FRAC_BITS{1'b0}}});

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic           v_in;
    meta_t          meta_in;
    logic [RMW-1:0] rem_in, rem2, trial, rem_nx;
    logic [RW-1:0]  root_in, root_nx;
    logic [XW-1:0]  x_in;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign meta_in = meta_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_first;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign meta_in = meta_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in    = x_q[k-1];
    end

    // one restoring root digit
    always_comb begin
      rem2  = {rem_in[RW-1:0], x_in[XW-1 -: 2]};
      trial = {root_in, 2'b01};
      if (rem2 >= trial) begin
        rem_nx  = rem2 - trial;
        root_nx = {root_in[RW-2:0], 1'b1};
      end else begin
        rem_nx  = rem2;
        root_nx = {root_in[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        meta_q[k] <= meta_in;
        rem_q[k]  <= rem_nx;
        root_q[k] <= root_nx;
        x_q[k]    <= x_in << 2;
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign meta_o  = meta_q[RW-1];
  assign root_o  = root_q[RW-1];

endmodule

// ===== rtl/core/fpv3_div.sv =====
// ----------------------------------------------------------------------------
// fpv3_div
// Pipelined three-lane unsigned divide of component magnitude, shifted up by
// the fraction width, over the magnitude; one quotient bit per stage.
// ----------------------------------------------------------------------------
module fpv3_div #(
  parameter int FRAC_BITS = fpv3_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  fpv3_pkg::meta_t             meta_i,
  output logic                        valid_o,
  output fpv3_pkg::meta_t             meta_o,
  output logic [fpv3_pkg::WORD_W-1:0] quot_o [fpv3_pkg::LANES],
  output logic                        ovf_o  [fpv3_pkg::LANES]
);
  import fpv3_pkg::*;

  localparam int RW = (WORD_W + FRAC_BITS) / 2;
  localparam int NS = WORD_W;

  logic              v_q    [NS];
  meta_t             meta_q [NS];
  logic [RW-1:0]     rem_q  [NS][LANES];
  logic [WORD_W-1:0] quo_q  [NS][LANES];
  logic [WORD_W-1:0] low_q  [NS][LANES];
  logic              ovf_q  [NS][LANES];

  logic [WORD_W-1:0] comp   [LANES];
  logic [WORD_W-1:0] mag    [LANES];
  logic [RW-1:0]     rem0   [LANES];
  logic [WORD_W-1:0] low0   [LANES];
  logic              ovf0   [LANES];
  logic [RW-1:0]     divisor;

  assign comp[0] = meta_i.ax;
  assign comp[1] = meta_i.ay;
  assign comp[2] = meta_i.az;
  assign divisor = meta_i.sc[RW-1:0];

  // split the shifted magnitude into a starting remainder and the bits to bring down
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag[l]  = comp[l][WORD_W-1] ? (~comp[l] + 1'b1) : comp[l];
      rem0[l] = RW'(mag[l][WORD_W-1 -: FRAC_BITS]);
      low0[l] = {mag[l][WORD_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      ovf0[l] = (rem0[l] >= divisor);
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic              v_in;
    meta_t             meta_in;
    logic [RW-1:0]     dv_in;
    logic [RW-1:0]     rem_in [LANES];
    logic [WORD_W-1:0] quo_in [LANES];
    logic [WORD_W-1:0] low_in [LANES];
    logic              ovf_in [LANES];
    logic [RW:0]       rem2   [LANES];
    logic [RW-1:0]     rem_nx [LANES];
    logic [WORD_W-1:0] quo_nx [LANES];

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign meta_in = meta_i;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_in[l] = rem0[l];
        assign quo_in[l] = '0;
        assign low_in[l] = low0[l];
        assign ovf_in[l] = ovf0[l];
      end
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign meta_in = meta_q[k-1];
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_in[l] = rem_q[k-1][l];
        assign quo_in[l] = quo_q[k-1][l];
        assign low_in[l] = low_q[k-1][l];
        assign ovf_in[l] = ovf_q[k-1][l];
      end
    end

    assign dv_in = meta_in.sc[RW-1:0];

    // one restoring quotient bit per lane
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        rem2[l] = {rem_in[l], low_in[l][WORD_W-1]};
        if (rem2[l] >= {1'b0, dv_in}) begin
          rem_nx[l] = RW'(rem2[l] - {1'b0, dv_in});
          quo_nx[l] = {quo_in[l][WORD_W-2:0], 1'b1};
        end else begin
          rem_nx[l] = rem2[l][RW-1:0];
          quo_nx[l] = {quo_in[l][WORD_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        meta_q[k] <= meta_in;
        for (int l = 0; l < LANES; l++) begin
          rem_q[k][l] <= rem_nx[l];
          quo_q[k][l] <= quo_nx[l];
          low_q[k][l] <= low_in[l] << 1;
          ovf_q[k][l] <= ovf_in[l];
        end
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign meta_o  = meta_q[NS-1];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quot_o[l] = quo_q[NS-1][l];
    assign ovf_o[l]  = ovf_q[NS-1][l];
  end

endmodule

// ===== rtl/core/fixed_point_vector3_alu_top.sv =====
// ----------------------------------------------------------------------------
// fixed_point_vector3_alu_top
// Fixed point three-component vector unit: add, subtract, scale, dot, cross,
// magnitude and normalize.
// ----------------------------------------------------------------------------
// One word is accepted every cycle while the output is not stalled, and one
// result word leaves for each, in order. Every word, whatever its operation,
// passes through two stages for the products and sums, one stage per root bit
// in the square root pipeline, one stage per quotient bit in the divide
// pipeline, and the output register. A stall at the output holds the whole
// pipeline and the input.
module fixed_point_vector3_alu_top #(
  parameter int FRAC_BITS = fpv3_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [2:0]                         kind_i,
  input  logic signed [fpv3_pkg::WORD_W-1:0] ax_i,
  input  logic signed [fpv3_pkg::WORD_W-1:0] ay_i,
  input  logic signed [fpv3_pkg::WORD_W-1:0] az_i,
  input  logic signed [fpv3_pkg::WORD_W-1:0] bx_i,
  input  logic signed [fpv3_pkg::WORD_W-1:0] by_i,
  input  logic signed [fpv3_pkg::WORD_W-1:0] bz_i,
  input  logic signed [fpv3_pkg::WORD_W-1:0] factor_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [fpv3_pkg::WORD_W-1:0] rx_o,
  output logic signed [fpv3_pkg::WORD_W-1:0] ry_o,
  output logic signed [fpv3_pkg::WORD_W-1:0] rz_o,
  output logic signed [fpv3_pkg::WORD_W-1:0] scalar_out_o,
  output logic                               zero_divide_o
);
  import fpv3_pkg::*;

  localparam int RW   = (WORD_W + FRAC_BITS) / 2;
  localparam int PW   = 2 * WORD_W;
  localparam int NMUL = 2 * LANES;

  localparam logic [WORD_W-1:0] SAT_POS = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] SAT_NEG = {1'b1, {(WORD_W-1){1'b0}}};

  logic en;

  // whole pipeline moves unless a finished word is held at the output
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // ---- stage a: operand select and products ----
  kind_e                    kind_in;
  logic signed [WORD_W-1:0] op_x [NMUL];
  logic signed [WORD_W-1:0] op_y [NMUL];
  logic [WORD_W-1:0]        vec_d [LANES];

  logic                     va_q;
  kind_e                    kind_a_q;
  logic [WORD_W-1:0]        a_a_q [LANES];
  logic [WORD_W-1:0]        vec_a_q [LANES];
  logic signed [PW-1:0]     p_q [NMUL];

  assign kind_in = kind_e'(kind_i);

  // operand routing per operation
  always_comb begin
    op_x[0] = ax_i;  op_x[1] = ay_i;  op_x[2] = az_i;
    op_y[0] = bx_i;  op_y[1] = by_i;  op_y[2] = bz_i;
    op_x[3] = az_i;  op_x[4] = ax_i;  op_x[5] = ay_i;
    op_y[3] = by_i;  op_y[4] = bz_i;  op_y[5] = bx_i;
    case (kind_in)
      KIND_SCALE: begin
        op_y[0] = factor_i;  op_y[1] = factor_i;  op_y[2] = factor_i;
      end
      KIND_MAG, KIND_NORM: begin
        op_y[0] = ax_i;  op_y[1] = ay_i;  op_y[2] = az_i;
      end
      KIND_CROSS: begin
        op_x[0] = ay_i;  op_x[1] = az_i;  op_x[2] = ax_i;
        op_y[0] = bz_i;  op_y[1] = bx_i;  op_y[2] = by_i;
      end
      default: ;
    endcase
  end

  // wrapping add and subtract
  always_comb begin
    case (kind_in)
      KIND_ADD: begin
        vec_d[0] = ax_i + bx_i;  vec_d[1] = ay_i + by_i;  vec_d[2] = az_i + bz_i;
      end
      KIND_SUB: begin
        vec_d[0] = ax_i - bx_i;  vec_d[1] = ay_i - by_i;  vec_d[2] = az_i - bz_i;
      end
      default: begin
        vec_d[0] = '0;  vec_d[1] = '0;  vec_d[2] = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_a_q   <= kind_in;
      a_a_q[0]   <= ax_i;
      a_a_q[1]   <= ay_i;
      a_a_q[2]   <= az_i;
      for (int l = 0; l < LANES; l++) begin
        vec_a_q[l] <= vec_d[l];
      end
      for (int i = 0; i < NMUL; i++) begin
        p_q[i] <= PW'(op_x[i]) * PW'(op_y[i]);
      end
    end
  end

  // ---- stage b: fixed point rescale and sums ----
  logic signed [PW-1:0] sh [NMUL];
  logic [WORD_W-1:0]    mp [NMUL];
  meta_t                meta_b_d;
  logic [WORD_W-1:0]    rad_b_d;

  logic                 vb_q;
  meta_t                meta_b_q;
  logic [WORD_W-1:0]    rad_b_q;

  always_comb begin
    for (int i = 0; i < NMUL; i++) begin
      sh[i] = p_q[i] >>> FRAC_BITS;
      mp[i] = sh[i][WORD_W-1:0];
    end
    meta_b_d      = '0;
    meta_b_d.kind = kind_a_q;
    meta_b_d.ax   = a_a_q[0];
    meta_b_d.ay   = a_a_q[1];
    meta_b_d.az   = a_a_q[2];
    rad_b_d       = mp[0] + mp[1] + mp[2];
    case (kind_a_q)
      KIND_ADD, KIND_SUB: begin
        meta_b_d.rx = vec_a_q[0];
        meta_b_d.ry = vec_a_q[1];
        meta_b_d.rz = vec_a_q[2];
      end
      KIND_SCALE: begin
        meta_b_d.rx = mp[0];
        meta_b_d.ry = mp[1];
        meta_b_d.rz = mp[2];
      end
      KIND_DOT: begin
        meta_b_d.sc = rad_b_d;
      end
      KIND_CROSS: begin
        meta_b_d.rx = mp[0] - mp[3];
        meta_b_d.ry = mp[1] - mp[4];
        meta_b_d.rz = mp[2] - mp[5];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_b_q <= meta_b_d;
      rad_b_q  <= rad_b_d;
    end
  end

  // ---- square root pipeline ----
  logic          vs;
  meta_t         meta_s;
  meta_t         meta_s_m;
  logic [RW-1:0] root_s;

  fpv3_sqrt #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vb_q),
    .meta_i  (meta_b_q),
    .rad_i   (rad_b_q),
    .valid_o (vs),
    .meta_o  (meta_s),
    .root_o  (root_s)
  );

  // magnitude joins the sideband
  always_comb begin
    meta_s_m = meta_s;
    if (meta_s.kind == KIND_MAG || meta_s.kind == KIND_NORM) begin
      meta_s_m.sc = WORD_W'(root_s);
    end
  end

  // ---- divide pipeline ----
  logic              vd;
  meta_t             meta_d;
  logic [WORD_W-1:0] quot [LANES];
  logic              ovf  [LANES];

  fpv3_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vs),
    .meta_i  (meta_s_m),
    .valid_o (vd),
    .meta_o  (meta_d),
    .quot_o  (quot),
    .ovf_o   (ovf)
  );

  // ---- output stage: sign, saturation and zero magnitude ----
  logic [WORD_W-1:0] comp [LANES];
  logic [WORD_W-1:0] res  [LANES];
  logic              zd_d;

  logic              out_valid_q;
  logic [WORD_W-1:0] rx_q, ry_q, rz_q, sc_q;
  logic              zd_q;

  assign comp[0] = meta_d.ax;
  assign comp[1] = meta_d.ay;
  assign comp[2] = meta_d.az;

  always_comb begin
    zd_d   = 1'b0;
    res[0] = meta_d.rx;
    res[1] = meta_d.ry;
    res[2] = meta_d.rz;
    if (meta_d.kind == KIND_NORM) begin
      zd_d = (meta_d.sc == '0);
      for (int l = 0; l < LANES; l++) begin
        if (zd_d) begin
          if (comp[l] == '0) begin
            res[l] = '0;
          end else if (comp[l][WORD_W-1]) begin
            res[l] = SAT_NEG;
          end else begin
            res[l] = SAT_POS;
          end
        end else if (comp[l][WORD_W-1]) begin
          res[l] = (ovf[l] || quot[l] > SAT_NEG) ? SAT_NEG : (~quot[l] + 1'b1);
        end else begin
          res[l] = (ovf[l] || quot[l][WORD_W-1]) ? SAT_POS : quot[l];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q <= res[0];
      ry_q <= res[1];
      rz_q <= res[2];
      sc_q <= meta_d.sc;
      zd_q <= zd_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign rx_o          = rx_q;
  assign ry_o          = ry_q;
  assign rz_o          = rz_q;
  assign scalar_out_o  = sc_q;
  assign zero_divide_o = zd_q;

  // ---- assertions ----
  // zero divide only comes with a zero magnitude
  a_zd_scalar : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_divide_o |-> scalar_out_o == '0)
    else $error("zero divide with nonzero magnitude");

  // zero divide components are saturated or zero
  a_zd_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_divide_o |->
      (rx_o == '0 || rx_o == SAT_POS || rx_o == SAT_NEG) &&
      (ry_o == '0 || ry_o == SAT_POS || ry_o == SAT_NEG) &&
      (rz_o == '0 || rz_o == SAT_POS || rz_o == SAT_NEG))
    else $error("zero divide component not saturated");

  // a held output freezes the pipeline head as well
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(va_q) && $stable(vb_q) && $stable(out_valid_o))
    else $error("pipeline moved while stalled");

endmodule

// ===== tb/fpv3_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fpv3_checker
// Watches both channels of the vector unit, predicts each result word from the
// accepted input word and compares them field by field, in order.
// ----------------------------------------------------------------------------
module fpv3_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] ax_i,
  input  logic signed [31:0] ay_i,
  input  logic signed [31:0] az_i,
  input  logic signed [31:0] bx_i,
  input  logic signed [31:0] by_i,
  input  logic signed [31:0] bz_i,
  input  logic signed [31:0] factor_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] rx_i,
  input  logic signed [31:0] ry_i,
  input  logic signed [31:0] rz_i,
  input  logic signed [31:0] scalar_i,
  input  logic               zero_divide_i,
  output int                 errors_o,
  output int                 pending_o
);
  import fpv3_pkg::*;

  typedef struct packed {
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
    logic [31:0] sc;
    logic        zd;
  } vec_result_t;

  vec_result_t result_q[$];

  assign pending_o = result_q.size();

  // fixed multiply: full product, arithmetic shift, low 32 bits
  function automatic logic [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return 32'(p >>> FRAC_BITS);
  endfunction

  function automatic logic [31:0] fx_root(logic [31:0] d);
    logic [63:0] x, res, bt;
    if (d[31]) return '0;
    x = 64'(d) << FRAC_BITS;
    res = '0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res[31:0];
  endfunction

  function automatic logic [31:0] fx_quot(logic signed [31:0] c, logic [31:0] m);
    logic signed [63:0] num, q;
    if (m == 0) begin
      if (c > 0) return 32'h7fff_ffff;
      if (c < 0) return 32'h8000_0000;
      return '0;
    end
    num = 64'(c) <<< FRAC_BITS;
    q = num / $signed({32'd0, m});
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic vec_result_t predict_vector(logic [2:0] kind,
      logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
      logic [31:0] bx, logic [31:0] by, logic [31:0] bz, logic [31:0] f);
    vec_result_t r;
    logic [31:0] m;
    r = '0;
    case (kind)
      KIND_ADD: begin
        r.rx = ax + bx; r.ry = ay + by; r.rz = az + bz;
      end
      KIND_SUB: begin
        r.rx = ax - bx; r.ry = ay - by; r.rz = az - bz;
      end
      KIND_SCALE: begin
        r.rx = fx_mul(ax, f); r.ry = fx_mul(ay, f); r.rz = fx_mul(az, f);
      end
      KIND_DOT: r.sc = fx_mul(ax, bx) + fx_mul(ay, by) + fx_mul(az, bz);
      KIND_CROSS: begin
        r.rx = fx_mul(ay, bz) - fx_mul(az, by);
        r.ry = fx_mul(az, bx) - fx_mul(ax, bz);
        r.rz = fx_mul(ax, by) - fx_mul(ay, bx);
      end
      KIND_MAG, KIND_NORM: begin
        m = fx_root(fx_mul(ax, ax) + fx_mul(ay, ay) + fx_mul(az, az));
        r.sc = m;
        if (kind == KIND_NORM) begin
          r.rx = fx_quot(ax, m); r.ry = fx_quot(ay, m); r.rz = fx_quot(az, m);
          r.zd = (m == 0);
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // predict on input words, compare on output words
  always @(posedge clk_i or negedge rst_ni) begin
    vec_result_t exp_r;
    if (!rst_ni) begin
      errors_o <= 0;
      result_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i)
        result_q.push_back(predict_vector(kind_i, ax_i, ay_i, az_i,
                                          bx_i, by_i, bz_i, factor_i));
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected word rx=%h ry=%h rz=%h sc=%h zd=%b", $time,
                   rx_i, ry_i, rz_i, scalar_i, zero_divide_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (exp_r != {rx_i, ry_i, rz_i, scalar_i, zero_divide_i}) begin
            $display("%0t: mismatch expected rx=%h ry=%h rz=%h sc=%h zd=%b", $time,
                     exp_r.rx, exp_r.ry, exp_r.rz, exp_r.sc, exp_r.zd);
            $display("%0t:          actual   rx=%h ry=%h rz=%h sc=%h zd=%b", $time,
                     rx_i, ry_i, rz_i, scalar_i, zero_divide_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_fixed_point_vector3_alu_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_point_vector3_alu_top
// Drives directed and random vector words into the unit with random gaps and
// output stalls, including a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb_fixed_point_vector3_alu_top;
  import fpv3_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int LATENCY = 3 + (32 + FRAC_BITS) / 2 + 32;
  localparam int N_RANDOM = 1130;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 3 * LATENCY;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid;
  logic out_stall = 1'b0;
  logic [2:0] kind;
  logic signed [31:0] ax, ay, az, bx, by, bz, factor;
  logic signed [31:0] rx, ry, rz, sc;
  logic zd;
  int errors, pending;
  int cycles = 0;
  int hold_cnt = 0;
  bit hold_go = 1'b0;

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  fixed_point_vector3_alu_top #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(kind), .ax_i(ax), .ay_i(ay), .az_i(az),
    .bx_i(bx), .by_i(by), .bz_i(bz), .factor_i(factor),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .rx_o(rx), .ry_o(ry), .rz_o(rz), .scalar_out_o(sc), .zero_divide_o(zd)
  );

  fpv3_checker #(.FRAC_BITS(FRAC_BITS)) checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .kind_i(kind), .ax_i(ax), .ay_i(ay), .az_i(az),
    .bx_i(bx), .by_i(by), .bz_i(bz), .factor_i(factor),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .rx_i(rx), .ry_i(ry), .rz_i(rz), .scalar_i(sc), .zero_divide_i(zd),
    .errors_o(errors), .pending_o(pending)
  );

  // mostly short gaps, sometimes long
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // component value: extremes, small fixed values or raw bits
  function automatic logic [31:0] rand_comp();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3, 4: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      5: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
      default: return $urandom;
    endcase
  endfunction

  // present one word and hold it until accepted
  task automatic send_word(logic [2:0] k, logic [31:0] vax, logic [31:0] vay,
      logic [31:0] vaz, logic [31:0] vbx, logic [31:0] vby, logic [31:0] vbz,
      logic [31:0] vf);
    in_valid <= 1'b1;
    kind <= k;
    ax <= vax; ay <= vay; az <= vaz;
    bx <= vbx; by <= vby; bz <= vbz; factor <= vf;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // receiver stall: random, periodically cleared, or held for a counted long stretch once started
  always @(posedge clk) begin
    if (hold_go && hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
      out_stall <= 1'b1;
    end
    else if (cycles % 500 < 150) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 30);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [2:0] k;
    rst_n = 1'b0;
    in_valid = 1'b0;
    kind = '0;
    {ax, ay, az, bx, by, bz, factor} = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every kind at extremes, zero magnitude, wrapped self-dot,
    // quotient overflow and the unused kind
    for (int i = 0; i <= 7; i++) begin
      send_word(3'(i), 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
                32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000);
    end
    send_word(KIND_NORM, 0, 0, 0, 0, 0, 0, 0);
    send_word(KIND_NORM, 32'h0000_0001, 32'hffff_ffff, 0, 0, 0, 0, 0);
    send_word(KIND_NORM, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 0, 0, 0, 0);
    send_word(KIND_MAG, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 0, 0, 0, 0);
    send_word(KIND_NORM, 32'h0003_0000, 32'hfffc_0000, 0, 0, 0, 0, 0);
    send_word(KIND_MAG, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0);
    send_word(KIND_SCALE, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000,
              0, 0, 0, 32'hffff_ffff);
    send_word(KIND_DOT, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff);
    send_word(KIND_CROSS, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0);
    send_word(KIND_ADD, 32'hffff_ffff, 32'h8000_0000, 0,
              32'h0000_0001, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

    // long receiver hold-off while words keep coming, so the pipeline fills
    hold_go = 1'b1;
    for (int i = 0; i < LATENCY + 40; i++)
      send_word(3'($urandom_range(7)), rand_comp(), rand_comp(), rand_comp(),
                rand_comp(), rand_comp(), rand_comp(), rand_comp());

    // random words; once in the middle pause until all results are back
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      k = ($urandom_range(19) == 0) ? 3'd7 : 3'($urandom_range(6));
      send_word(k, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                rand_comp(), rand_comp(), rand_comp());
      idle_cycles(gap_len());
    end
    in_valid <= 1'b0;

    // drain, then let the pipeline settle before the verdict
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
